// ===== design/rcss_pkg.sv =====
// Shared types and constants for the remote channel select sequencer.
package rcss_pkg;

    localparam int CH_W = 3;
    localparam logic [CH_W-1:0] CH3_IDX = 3'd2;
    localparam logic [CH_W-1:0] CAL_IDX = 3'd3;

    typedef enum logic [3:0] {
        MODE_TICK   = 4'd0,
        MODE_OPEN   = 4'd1,
        MODE_CLOSE  = 4'd2,
        MODE_STOP   = 4'd3,
        MODE_SELECT = 4'd4,
        MODE_P_SEL  = 4'd5,
        MODE_P_UP   = 4'd6,
        MODE_P_DOWN = 4'd7,
        MODE_P_MY   = 4'd8,
        MODE_CAL    = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RESET   = 3'd1,
        PH_STABLE  = 3'd2,
        PH_CHECK   = 3'd3,
        PH_SELREL  = 3'd4,
        PH_SELNEXT = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        BTN_NONE   = 3'd0,
        BTN_SELECT = 3'd1,
        BTN_UP     = 3'd2,
        BTN_DOWN   = 3'd3,
        BTN_MY     = 3'd4
    } btn_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_MY   = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        CFG_PRESS_DURATION = 3'd0,
        CFG_STABLE_DELAY   = 3'd1,
        CFG_PRESS_MARGIN   = 3'd2,
        CFG_MAX_RESETS     = 3'd3,
        CFG_SYNC_INTERVAL  = 3'd4,
        CFG_SYNC_HOLD      = 3'd5,
        CFG_LEDS_PRESENT   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] press_duration_ms;
        logic [15:0] stable_delay_ms;
        logic [15:0] press_margin_ms;
        logic [3:0]  reset_press_limit;
        logic [15:0] sync_interval_ms;
        logic [15:0] sync_hold_ms;
        logic        leds_present;
    } cfg_t;

    typedef struct packed {
        btn_t            drive_button;
        logic            ready_res;
        logic [CH_W-1:0] active_channel;
        logic            select_failed;
    } res_t;

    function automatic btn_t act_button(input act_t a);
        btn_t b;
        case (a)
            ACT_UP:   b = BTN_UP;
            ACT_DOWN: b = BTN_DOWN;
            ACT_MY:   b = BTN_MY;
            default:  b = BTN_NONE;
        endcase
        return b;
    endfunction

endpackage

// ===== design/rcss_core.sv =====
// Sequencer state and the single-pass per-item update logic.
module rcss_core
    import rcss_pkg::*;
#(
    parameter int NUM_CHANNELS = 5,
    parameter int TIME_BITS    = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic [3:0]      mode,
    input  logic [CH_W-1:0] target_idx,
    input  logic            led3_on,
    input  logic            led4_on,
    input  cfg_t            cfg,
    output res_t            res
);

    localparam int CW = TIME_BITS + 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
    localparam logic [3:0] NUM_CH4 = 4'(NUM_CHANNELS);
    localparam logic [3:0] SEL_OFF = 4'(NUM_CHANNELS - 2);

    phase_t                ph_reg, ph_next;
    logic [CH_W-1:0]       ch_reg, ch_next;
    logic [CH_W-1:0]       tgt_reg, tgt_next;
    logic [CH_W-1:0]       pl_reg, pl_next;
    logic [3:0]            rpc_reg, rpc_next;
    act_t                  qa_reg, qa_next;
    btn_t                  hb_reg, hb_next;
    logic                  aor_reg, aor_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TIME_BITS-1:0]  pst_reg, pst_next;
    logic [TIME_BITS-1:0]  wst_reg, wst_next;
    logic [TIME_BITS-1:0]  lsy_reg, lsy_next;
    logic [TIME_BITS-1:0]  ldn_reg, ldn_next;

    logic                  led3, led4, l3only;
    logic                  idx_ok, sel_go, fail;
    logic [3:0]            nsum, nmod;
    logic [CW-1:0]         gap_ms;
    mode_t                 mode_dec;

    assign led3     = cfg.leds_present & led3_on;
    assign led4     = cfg.leds_present & led4_on;
    assign l3only   = led3 & ~led4;
    assign idx_ok   = (target_idx <= LAST_CH);
    assign nsum     = {1'b0, target_idx} + SEL_OFF;
    assign nmod     = (nsum >= NUM_CH4) ? (nsum - NUM_CH4) : nsum;
    assign gap_ms   = CW'(cfg.press_duration_ms) + CW'(cfg.press_margin_ms);
    assign mode_dec = mode_t'(mode);

    always_comb
    begin
        ph_next  = ph_reg;
        ch_next  = ch_reg;
        tgt_next = tgt_reg;
        pl_next  = pl_reg;
        rpc_next = rpc_reg;
        qa_next  = qa_reg;
        hb_next  = hb_reg;
        aor_next = aor_reg;
        now_next = now_reg;
        pst_next = pst_reg;
        wst_next = wst_reg;
        lsy_next = lsy_reg;
        ldn_next = ldn_reg;
        sel_go   = 1'b0;
        fail     = 1'b0;

        case (mode_dec)
            MODE_TICK:
            begin
                now_next = now_reg + 1'b1;
                if (ph_next == PH_IDLE
                    && (now_next - lsy_next) > TIME_BITS'(cfg.sync_interval_ms)
                    && (now_next - ldn_next) > TIME_BITS'(cfg.sync_hold_ms))
                begin
                    if (l3only)
                        ch_next = CH3_IDX;
                    else if (!led3 && led4)
                        ch_next = CAL_IDX;
                    lsy_next = now_next;
                end
                case (ph_next)
                    PH_IDLE:
                    begin
                    end
                    PH_RESET:
                    begin
                        if (hb_next == BTN_NONE)
                        begin
                            ph_next  = PH_STABLE;
                            wst_next = now_next;
                        end
                    end
                    PH_STABLE:
                    begin
                        if ((now_next - wst_next) >= TIME_BITS'(cfg.stable_delay_ms))
                            ph_next = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        if (l3only)
                        begin
                            ch_next = CH3_IDX;
                            if (pl_next == '0)
                            begin
                                ph_next  = PH_IDLE;
                                ldn_next = now_next;
                                if (qa_next != ACT_NONE && hb_next == BTN_NONE)
                                begin
                                    hb_next  = act_button(qa_next);
                                    aor_next = 1'b0;
                                    pst_next = now_next;
                                end
                                qa_next = ACT_NONE;
                            end
                            else
                            begin
                                ph_next  = PH_SELREL;
                                wst_next = now_next;
                                hb_next  = BTN_SELECT;
                                aor_next = 1'b1;
                                pst_next = now_next;
                            end
                        end
                        else if (rpc_next >= cfg.reset_press_limit)
                        begin
                            ph_next = PH_IDLE;
                            qa_next = ACT_NONE;
                            fail    = 1'b1;
                        end
                        else
                        begin
                            rpc_next = rpc_next + 4'd1;
                            hb_next  = BTN_SELECT;
                            aor_next = 1'b0;
                            pst_next = now_next;
                            ph_next  = PH_RESET;
                        end
                    end
                    PH_SELREL:
                    begin
                        if (hb_next == BTN_NONE)
                        begin
                            if (pl_next != '0)
                                pl_next = pl_next - 1'b1;
                            if (pl_next == '0)
                            begin
                                ch_next  = tgt_next;
                                ph_next  = PH_IDLE;
                                ldn_next = now_next;
                                if (qa_next != ACT_NONE)
                                begin
                                    hb_next  = act_button(qa_next);
                                    aor_next = 1'b0;
                                    pst_next = now_next;
                                end
                                qa_next = ACT_NONE;
                            end
                            else
                            begin
                                ph_next  = PH_SELNEXT;
                                wst_next = now_next;
                            end
                        end
                    end
                    PH_SELNEXT:
                    begin
                        if ({1'b0, TIME_BITS'(now_next - wst_next)} >= gap_ms)
                        begin
                            hb_next  = BTN_SELECT;
                            aor_next = 1'b1;
                            pst_next = now_next;
                            ph_next  = PH_SELREL;
                        end
                    end
                    default:
                        ph_next = PH_IDLE;
                endcase
                if (hb_next != BTN_NONE
                    && (now_next - pst_next) >= TIME_BITS'(cfg.press_duration_ms))
                begin
                    if (aor_next)
                    begin
                        ch_next  = (ch_next == LAST_CH) ? '0 : ch_next + 1'b1;
                        aor_next = 1'b0;
                    end
                    hb_next = BTN_NONE;
                end
            end
            MODE_OPEN, MODE_CLOSE, MODE_STOP:
            begin
                if (idx_ok)
                begin
                    if (ch_next == target_idx && ph_next == PH_IDLE)
                    begin
                        if (hb_next == BTN_NONE)
                        begin
                            hb_next  = (mode_dec == MODE_OPEN)  ? BTN_UP :
                                       (mode_dec == MODE_CLOSE) ? BTN_DOWN : BTN_MY;
                            aor_next = 1'b0;
                            pst_next = now_next;
                        end
                    end
                    else
                    begin
                        qa_next = (mode_dec == MODE_OPEN)  ? ACT_UP :
                                  (mode_dec == MODE_CLOSE) ? ACT_DOWN : ACT_MY;
                        sel_go  = 1'b1;
                    end
                end
            end
            MODE_SELECT:
                sel_go = idx_ok;
            MODE_P_SEL, MODE_P_UP, MODE_P_DOWN, MODE_P_MY:
            begin
                if (ph_next == PH_IDLE && hb_next == BTN_NONE)
                begin
                    hb_next  = (mode_dec == MODE_P_SEL)  ? BTN_SELECT :
                               (mode_dec == MODE_P_UP)   ? BTN_UP :
                               (mode_dec == MODE_P_DOWN) ? BTN_DOWN : BTN_MY;
                    aor_next = 1'b0;
                    pst_next = now_next;
                end
            end
            MODE_CAL:
                ch_next = CAL_IDX;
            default:
            begin
            end
        endcase

        if (sel_go)
        begin
            // cancel a running selection and drop its select press
            if (ph_next != PH_IDLE)
            begin
                ph_next = PH_IDLE;
                if (hb_next == BTN_SELECT)
                begin
                    hb_next  = BTN_NONE;
                    aor_next = 1'b0;
                end
            end
            if (hb_next == BTN_NONE)
            begin
                if (ch_next == target_idx || (l3only && nmod == 4'd0))
                begin
                    if (ch_next != target_idx)
                    begin
                        tgt_next = target_idx;
                        pl_next  = '0;
                        ch_next  = CH3_IDX;
                    end
                    if (qa_next != ACT_NONE)
                    begin
                        hb_next  = act_button(qa_next);
                        aor_next = 1'b0;
                        pst_next = now_next;
                    end
                    qa_next = ACT_NONE;
                end
                else if (cfg.leds_present)
                begin
                    tgt_next = target_idx;
                    pl_next  = nmod[CH_W-1:0];
                    wst_next = now_next;
                    hb_next  = BTN_SELECT;
                    pst_next = now_next;
                    if (l3only)
                    begin
                        ch_next  = CH3_IDX;
                        ph_next  = PH_SELREL;
                        aor_next = 1'b1;
                    end
                    else
                    begin
                        ph_next  = PH_RESET;
                        rpc_next = 4'd1;
                        aor_next = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res.drive_button   = hb_next;
        res.ready_res      = (ph_next == PH_IDLE) && (hb_next == BTN_NONE);
        res.active_channel = ch_next;
        res.select_failed  = fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            ch_reg  <= '0;
            tgt_reg <= '0;
            pl_reg  <= '0;
            rpc_reg <= '0;
            qa_reg  <= ACT_NONE;
            hb_reg  <= BTN_NONE;
            aor_reg <= 1'b0;
            now_reg <= '0;
            pst_reg <= '0;
            wst_reg <= '0;
            lsy_reg <= '0;
            ldn_reg <= '0;
        end
        else if (step_en)
        begin
            ph_reg  <= ph_next;
            ch_reg  <= ch_next;
            tgt_reg <= tgt_next;
            pl_reg  <= pl_next;
            rpc_reg <= rpc_next;
            qa_reg  <= qa_next;
            hb_reg  <= hb_next;
            aor_reg <= aor_next;
            now_reg <= now_next;
            pst_reg <= pst_next;
            wst_reg <= wst_next;
            lsy_reg <= lsy_next;
            ldn_reg <= ldn_next;
        end
    end

    a_aor_needs_select: assert property (@(posedge clk) disable iff (!rst_n)
        aor_reg |-> hb_reg == BTN_SELECT)
        else $error("advance pending without select held");

    a_selnext_released: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_SELNEXT |-> hb_reg == BTN_NONE)
        else $error("button held while waiting for next select press");

    a_presses_range: assert property (@(posedge clk) disable iff (!rst_n)
        pl_reg <= LAST_CH)
        else $error("presses left out of range");

endmodule

// ===== design/remote_channel_select_sequencer.sv =====
// Top level: input stage, config registers, sequencer core and result stage.
// An accepted item waits in the input register; its result goes to the result register.
// Throughput: one item per cycle when not stalled; the single-pass core updates all
// state per item. The input register holds while the result register is stalled.
// Reset (rst_n low, asynchronous) empties both stages, idles the sequencer,
// clears channel, counters and time stamps, and loads the default config.
module remote_channel_select_sequencer
    import rcss_pkg::*;
#(
    parameter int NUM_CHANNELS = 5,
    parameter int TIME_BITS    = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [3:0]      mode,
    input  logic [CH_W-1:0] target_idx,
    input  logic            led3_on,
    input  logic            led4_on,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      drive_button,
    output logic            ready_res,
    output logic [CH_W-1:0] active_channel,
    output logic            select_failed,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    logic            in_valid_reg;
    logic [3:0]      mode_reg;
    logic [CH_W-1:0] idx_reg;
    logic            led3_reg, led4_reg;
    logic            out_valid_reg;
    res_t            res_reg, res_next;
    cfg_t            cfg_reg;
    logic            step_en, in_take;

    assign step_en   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step_en;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_duration_ms <= 16'd200;
            cfg_reg.stable_delay_ms   <= 16'd500;
            cfg_reg.press_margin_ms   <= 16'd100;
            cfg_reg.reset_press_limit <= 4'd10;
            cfg_reg.sync_interval_ms  <= 16'd1000;
            cfg_reg.sync_hold_ms      <= 16'd2000;
            cfg_reg.leds_present      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRESS_DURATION: cfg_reg.press_duration_ms <= cfg_data;
                CFG_STABLE_DELAY:   cfg_reg.stable_delay_ms   <= cfg_data;
                CFG_PRESS_MARGIN:   cfg_reg.press_margin_ms   <= cfg_data;
                CFG_MAX_RESETS:     cfg_reg.reset_press_limit <= cfg_data[3:0];
                CFG_SYNC_INTERVAL:  cfg_reg.sync_interval_ms  <= cfg_data;
                CFG_SYNC_HOLD:      cfg_reg.sync_hold_ms      <= cfg_data;
                CFG_LEDS_PRESENT:   cfg_reg.leds_present      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step_en)
                in_valid_reg <= 1'b0;
            if (step_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            idx_reg  <= target_idx;
            led3_reg <= led3_on;
            led4_reg <= led4_on;
        end
        if (step_en)
            res_reg <= res_next;
    end

    rcss_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .mode        (mode_reg),
        .target_idx  (idx_reg),
        .led3_on     (led3_reg),
        .led4_on     (led4_reg),
        .cfg         (cfg_reg),
        .res         (res_next)
    );

    assign out_valid      = out_valid_reg;
    assign drive_button   = res_reg.drive_button;
    assign ready_res      = res_reg.ready_res;
    assign active_channel = res_reg.active_channel;
    assign select_failed  = res_reg.select_failed;

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled while result stage can drain");

    a_failed_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.select_failed |-> res_reg.ready_res)
        else $error("select failure reported while not ready");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.active_channel <= CH_W'(NUM_CHANNELS - 1))
        else $error("active channel out of range");

endmodule
